>>> src/emrx_pkg.sv
// Shared types and constants for the Ethernet receive filter / ethertype classifier.
// No dependencies; compiled before every other file of the block.
package emrx_pkg;

    // Defaults for the top-level parameters
    localparam int PROTO_SLOTS_DEF     = 4;
    localparam int MAX_FRAME_BYTES_DEF = 2048;

    // Fixed field widths
    localparam int MAC_W   = 48;
    localparam int TYPE_W  = 16;
    localparam int SLOT_W  = 2;
    localparam int SLOTS_MAX = 4;
    localparam int PLEN_W  = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // Frame layout
    localparam int MAC_BYTES = 6;
    localparam int TYPE_HI_POS = 12;
    localparam int TYPE_LO_POS = 13;
    localparam int HDR_LEN = 14;
    localparam logic [7:0] BCAST_BYTE = 8'hFF;

    // Result FIFO
    localparam int RES_FIFO_DEPTH = 8;
    localparam int RES_FIFO_AW    = 3;
    localparam int RES_FIFO_CW    = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STATION_MAC  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROTO_TYPE_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROTO_TYPE_1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PROTO_TYPE_2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PROTO_TYPE_3 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PROTO_VALID  = 3'd5;

    // Verdict codes
    localparam logic [1:0] V_DELIVERED  = 2'd0;
    localparam logic [1:0] V_SHORT      = 2'd1;
    localparam logic [1:0] V_ADDR       = 2'd2;
    localparam logic [1:0] V_NOHANDLER  = 2'd3;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef struct packed {
        logic [MAC_W-1:0]                station_mac;
        logic [SLOTS_MAX-1:0][TYPE_W-1:0] proto_type;
        logic [SLOTS_MAX-1:0]            proto_valid;
    } cfg_t;

    typedef struct packed {
        logic              result_kind;
        logic [7:0]        payload_byte;
        logic [SLOT_W-1:0] proto_slot;
        logic [1:0]        verdict;
        logic [TYPE_W-1:0] ethertype;
        logic [PLEN_W-1:0] payload_len;
        logic              run_last;
    } result_t;

    // Up to two results per byte, pushed into the result FIFO together
    typedef struct packed {
        logic    first_valid;
        logic    second_valid;
        result_t first;
        result_t second;
    } push_t;

endpackage

>>> src/emrx_if.sv
// Channel interfaces: receive byte stream, result stream, configuration writes.
// Depends on emrx_pkg.
interface emrx_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_end;

    modport source (output valid, output rx_byte, output frame_end, input ready);
    modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface emrx_res_if;
    logic                         valid;
    logic                         ready;
    logic                         result_kind;
    logic [7:0]                   payload_byte;
    logic [emrx_pkg::SLOT_W-1:0]  proto_slot;
    logic [1:0]                   verdict;
    logic [emrx_pkg::TYPE_W-1:0]  ethertype;
    logic [emrx_pkg::PLEN_W-1:0]  payload_len;
    logic                         run_last;

    modport source (output valid, output result_kind, output payload_byte,
                    output proto_slot, output verdict, output ethertype,
                    output payload_len, output run_last, input ready);
    modport sink   (input valid, input result_kind, input payload_byte,
                    input proto_slot, input verdict, input ethertype,
                    input payload_len, input run_last, output ready);
endinterface

interface emrx_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [emrx_pkg::CFG_IDX_W-1:0]   index;
    logic [emrx_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/emrx_cfg_regs.sv
// Configuration register file: station MAC, four ethertype slots, slot valid mask.
// Depends on emrx_pkg.
module emrx_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [emrx_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [emrx_pkg::CFG_DATA_W-1:0] wr_data,
    output emrx_pkg::cfg_t                  cfg
);
    emrx_pkg::cfg_t cfg_reg;
    emrx_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                emrx_pkg::CFG_STATION_MAC:
                    cfg_next.station_mac = wr_data[emrx_pkg::MAC_W-1:0];
                emrx_pkg::CFG_PROTO_TYPE_0:
                    cfg_next.proto_type[0] = wr_data[emrx_pkg::TYPE_W-1:0];
                emrx_pkg::CFG_PROTO_TYPE_1:
                    cfg_next.proto_type[1] = wr_data[emrx_pkg::TYPE_W-1:0];
                emrx_pkg::CFG_PROTO_TYPE_2:
                    cfg_next.proto_type[2] = wr_data[emrx_pkg::TYPE_W-1:0];
                emrx_pkg::CFG_PROTO_TYPE_3:
                    cfg_next.proto_type[3] = wr_data[emrx_pkg::TYPE_W-1:0];
                emrx_pkg::CFG_PROTO_VALID:
                    cfg_next.proto_valid = wr_data[emrx_pkg::SLOTS_MAX-1:0];
                default:
                    cfg_next = cfg_reg;   // unknown index: ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;
endmodule

>>> src/emrx_classifier.sv
// Per-byte frame parser: input register, address filter, ethertype lookup,
// payload and verdict result generation. Depends on emrx_pkg.
module emrx_classifier #(
    parameter int PROTO_SLOTS     = emrx_pkg::PROTO_SLOTS_DEF,
    parameter int MAX_FRAME_BYTES = emrx_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [7:0]     in_byte,
    input  logic           in_end,
    input  emrx_pkg::cfg_t cfg,
    output logic           busy,
    output emrx_pkg::push_t push
);
    localparam int IDX_W = $clog2(MAX_FRAME_BYTES);
    localparam logic [IDX_W-1:0] IDX_SAT = IDX_W'(MAX_FRAME_BYTES - 1);
    localparam logic [IDX_W-1:0] POS_MAC_END = IDX_W'(emrx_pkg::MAC_BYTES);
    localparam logic [IDX_W-1:0] POS_TYPE_HI = IDX_W'(emrx_pkg::TYPE_HI_POS);
    localparam logic [IDX_W-1:0] POS_TYPE_LO = IDX_W'(emrx_pkg::TYPE_LO_POS);
    localparam logic [IDX_W-1:0] POS_HDR     = IDX_W'(emrx_pkg::HDR_LEN);

    // input register
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_end_reg;

    // frame state
    logic [IDX_W-1:0]            idx_reg,      idx_next;
    logic                        own_reg,      own_next;
    logic                        bcast_reg,    bcast_next;
    logic [7:0]                  type_hi_reg,  type_hi_next;
    logic                        accept_reg,   accept_next;
    logic [1:0]                  verdict_reg,  verdict_next;
    logic [emrx_pkg::SLOT_W-1:0] slot_reg,     slot_next;
    logic [emrx_pkg::TYPE_W-1:0] ftype_reg,    ftype_next;

    logic [IDX_W-1:0]            total;
    logic [7:0]                  mac_byte;
    logic [emrx_pkg::TYPE_W-1:0] rx_type;
    logic                        hit;
    logic [emrx_pkg::SLOT_W-1:0] hit_slot;
    logic [emrx_pkg::PLEN_W-1:0] plen;
    logic                        pay_en;
    emrx_pkg::result_t           pay_res;
    emrx_pkg::result_t           vrd_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            s1_byte_reg <= in_byte;
            s1_end_reg  <= in_end;
        end
    end

    assign total   = (idx_reg == IDX_SAT) ? idx_reg : idx_reg + 1'b1;
    assign plen    = emrx_pkg::PLEN_W'(total - POS_HDR);
    assign rx_type = {type_hi_reg, s1_byte_reg};

    // station MAC byte for this position; first wire byte is the top byte
    always_comb
    begin
        case (idx_reg[2:0])
            3'd0:    mac_byte = cfg.station_mac[47:40];
            3'd1:    mac_byte = cfg.station_mac[39:32];
            3'd2:    mac_byte = cfg.station_mac[31:24];
            3'd3:    mac_byte = cfg.station_mac[23:16];
            3'd4:    mac_byte = cfg.station_mac[15:8];
            default: mac_byte = cfg.station_mac[7:0];
        endcase
    end

    // lowest matching valid slot wins
    always_comb
    begin
        hit      = 1'b0;
        hit_slot = '0;
        for (int i = PROTO_SLOTS - 1; i >= 0; i--)
        begin
            if (cfg.proto_valid[i] && cfg.proto_type[i] == rx_type)
            begin
                hit      = 1'b1;
                hit_slot = emrx_pkg::SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        idx_next     = idx_reg;
        own_next     = own_reg;
        bcast_next   = bcast_reg;
        type_hi_next = type_hi_reg;
        accept_next  = accept_reg;
        verdict_next = verdict_reg;
        slot_next    = slot_reg;
        ftype_next   = ftype_reg;

        if (idx_reg < POS_MAC_END)
        begin
            if (s1_byte_reg != mac_byte)
                own_next = 1'b0;
            if (s1_byte_reg != emrx_pkg::BCAST_BYTE)
                bcast_next = 1'b0;
        end
        else if (idx_reg == POS_TYPE_HI)
        begin
            type_hi_next = s1_byte_reg;
        end
        else if (idx_reg == POS_TYPE_LO)
        begin
            ftype_next = rx_type;
            if (!own_reg && !bcast_reg)
                verdict_next = emrx_pkg::V_ADDR;
            else if (hit)
            begin
                verdict_next = emrx_pkg::V_DELIVERED;
                accept_next  = 1'b1;
                slot_next    = hit_slot;
            end
            else
                verdict_next = emrx_pkg::V_NOHANDLER;
        end

        pay_en = (idx_reg >= POS_HDR) && accept_reg;

        pay_res.result_kind  = emrx_pkg::KIND_PAYLOAD;
        pay_res.payload_byte = s1_byte_reg;
        pay_res.proto_slot   = slot_reg;
        pay_res.verdict      = emrx_pkg::V_DELIVERED;
        pay_res.ethertype    = ftype_reg;
        pay_res.payload_len  = plen;
        pay_res.run_last     = !s1_end_reg;

        vrd_res.result_kind  = emrx_pkg::KIND_VERDICT;
        vrd_res.payload_byte = '0;
        vrd_res.run_last     = 1'b1;
        if (total < POS_HDR)
        begin
            vrd_res.proto_slot  = '0;
            vrd_res.verdict     = emrx_pkg::V_SHORT;
            vrd_res.ethertype   = '0;
            vrd_res.payload_len = '0;
        end
        else
        begin
            vrd_res.proto_slot  = (verdict_next == emrx_pkg::V_DELIVERED) ? slot_next : '0;
            vrd_res.verdict     = verdict_next;
            vrd_res.ethertype   = ftype_next;
            vrd_res.payload_len = plen;
        end

        if (s1_end_reg)
        begin
            idx_next     = '0;
            own_next     = 1'b1;
            bcast_next   = 1'b1;
            type_hi_next = '0;
            accept_next  = 1'b0;
            verdict_next = emrx_pkg::V_SHORT;
            slot_next    = '0;
            ftype_next   = '0;
        end
        else
        begin
            idx_next = total;
        end
    end

    always_comb
    begin
        push.first_valid  = s1_valid_reg && (pay_en || s1_end_reg);
        push.second_valid = s1_valid_reg && pay_en && s1_end_reg;
        push.first        = pay_en ? pay_res : vrd_res;
        push.second       = vrd_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            own_reg     <= 1'b1;
            bcast_reg   <= 1'b1;
            type_hi_reg <= '0;
            accept_reg  <= 1'b0;
            verdict_reg <= emrx_pkg::V_SHORT;
            slot_reg    <= '0;
            ftype_reg   <= '0;
        end
        else if (s1_valid_reg)
        begin
            idx_reg     <= idx_next;
            own_reg     <= own_next;
            bcast_reg   <= bcast_next;
            type_hi_reg <= type_hi_next;
            accept_reg  <= accept_next;
            verdict_reg <= verdict_next;
            slot_reg    <= slot_next;
            ftype_reg   <= ftype_next;
        end
    end

    assign busy = s1_valid_reg;
endmodule

>>> src/emrx_result_fifo.sv
// Result FIFO: takes up to two results per cycle, hands out one per transaction.
// Depends on emrx_pkg.
module emrx_result_fifo (
    input  logic                                clk,
    input  logic                                rst_n,
    input  emrx_pkg::push_t                     push,
    input  logic                                pop,
    output logic                                head_valid,
    output emrx_pkg::result_t                   head,
    output logic [emrx_pkg::RES_FIFO_CW-1:0]    count
);
    localparam int AW = emrx_pkg::RES_FIFO_AW;
    localparam int CW = emrx_pkg::RES_FIFO_CW;

    emrx_pkg::result_t entry_reg [emrx_pkg::RES_FIFO_DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg,  count_next;
    logic [CW-1:0] push_n;
    logic          do_pop;

    assign do_pop = pop && (count_reg != '0);
    assign push_n = CW'(push.first_valid) + CW'(push.second_valid);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + AW'(push_n);
        rd_ptr_next = rd_ptr_reg + AW'(do_pop);
        count_next  = count_reg + push_n - CW'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.first_valid)
            entry_reg[wr_ptr_reg] <= push.first;
        if (push.second_valid)
            entry_reg[wr_ptr_reg + 1'b1] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign count      = count_reg;
endmodule

>>> src/ethernet_rx_mac_filter_classifier.sv
// Top level of the Ethernet receive destination filter and ethertype classifier.
// Depends on emrx_pkg, emrx_if, emrx_cfg_regs, emrx_classifier, emrx_result_fifo.
//
// Usage:
//   rx  : one frame byte per transaction, frame_end on the last byte. Bytes 0-5
//         are checked against station MAC and broadcast, bytes 12-13 give the
//         ethertype, looked up in the registered slots.
//   res : one result per transaction. Accepted frames yield one payload result
//         per byte from byte 14 on; the last byte of every frame adds a
//         verdict result (delivered, too short, address mismatch, no handler).
//   cfg : register writes (index, data); always ready, applied next cycle.
//         Write only while no frame is in flight.
// Timing: results are pushed into the result FIFO in the cycle after the byte is
//   accepted, from the input register, and are then taken from the FIFO head.
// Throughput: one byte per cycle while rx.ready is high. The last byte of an
//   accepted frame with payload yields two results, so the 8-entry result FIFO
//   absorbs one extra per frame and drains one per cycle while res.ready is high.
// Reset: clears frame state, registers and FIFO; the next byte starts a frame.
// Stall: rx.ready is high only while the FIFO has room for two results of a new
//   byte plus two of the byte in the input register; res.ready low fills it.
module ethernet_rx_mac_filter_classifier #(
    parameter int PROTO_SLOTS     = emrx_pkg::PROTO_SLOTS_DEF,
    parameter int MAX_FRAME_BYTES = emrx_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    emrx_rx_if.sink     rx,
    emrx_res_if.source  res,
    emrx_cfg_if.sink    cfg
);
    localparam int CW = emrx_pkg::RES_FIFO_CW;
    // room check: byte in the input register plus the new one, two results each
    localparam logic [CW:0] ROOM_LIMIT = (CW+1)'(emrx_pkg::RES_FIFO_DEPTH - 2);

    emrx_pkg::cfg_t    cfg_val;
    emrx_pkg::push_t   push;
    emrx_pkg::result_t head;
    logic              head_valid;
    logic [CW-1:0]     fifo_count;
    logic              s1_busy;
    logic              rx_take;
    logic [CW:0]       fifo_need;

    assign cfg.ready = 1'b1;

    emrx_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_val)
    );

    // worst case: both the registered byte and the new byte push two results
    assign fifo_need = {1'b0, fifo_count} + (s1_busy ? (CW+1)'(2) : '0);
    assign rx.ready  = (fifo_need <= ROOM_LIMIT);
    assign rx_take   = rx.valid && rx.ready;

    emrx_classifier #(
        .PROTO_SLOTS     (PROTO_SLOTS),
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_cls (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rx_take),
        .in_byte  (rx.rx_byte),
        .in_end   (rx.frame_end),
        .cfg      (cfg_val),
        .busy     (s1_busy),
        .push     (push)
    );

    emrx_result_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (res.ready),
        .head_valid (head_valid),
        .head       (head),
        .count      (fifo_count)
    );

    assign res.valid        = head_valid;
    assign res.result_kind  = head.result_kind;
    assign res.payload_byte = head.payload_byte;
    assign res.proto_slot   = head.proto_slot;
    assign res.verdict      = head.verdict;
    assign res.ethertype    = head.ethertype;
    assign res.payload_len  = head.payload_len;
    assign res.run_last     = head.run_last;
endmodule

>>> src/emrx_checker.sv
// Port-level checker for the receive classifier, bound to the top level.
// Depends on emrx_pkg and ethernet_rx_mac_filter_classifier.
module emrx_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        res_valid,
    input logic                        res_ready,
    input logic                        result_kind,
    input logic [7:0]                  payload_byte,
    input logic [1:0]                  verdict,
    input logic [emrx_pkg::TYPE_W-1:0] ethertype,
    input logic [emrx_pkg::PLEN_W-1:0] payload_len,
    input logic                        run_last
);
    // a stalled transaction holds its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(result_kind)
            && $stable(payload_byte) && $stable(verdict) && $stable(payload_len))
        else $error("result changed while stalled");

    // payload only flows for delivered frames
    a_pay_deliv: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && result_kind == emrx_pkg::KIND_PAYLOAD
            |-> verdict == emrx_pkg::V_DELIVERED)
        else $error("payload result with non-delivered verdict");

    // too-short frames carry no type and no length
    a_short: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && result_kind == emrx_pkg::KIND_VERDICT
            && verdict == emrx_pkg::V_SHORT |-> ethertype == '0 && payload_len == '0)
        else $error("too-short verdict with nonzero fields");

    // a last-byte payload result is followed right away by its verdict
    a_pay_then_vrd: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && result_kind == emrx_pkg::KIND_PAYLOAD && !run_last
            |=> res_valid && result_kind == emrx_pkg::KIND_VERDICT && run_last)
        else $error("verdict did not follow final payload byte");
endmodule

bind ethernet_rx_mac_filter_classifier emrx_checker u_emrx_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .result_kind  (res.result_kind),
    .payload_byte (res.payload_byte),
    .verdict      (res.verdict),
    .ethertype    (res.ethertype),
    .payload_len  (res.payload_len),
    .run_last     (res.run_last)
);

>>> sim/ethernet_rx_mac_filter_classifier_test.sv
// Self-checking testbench for the Ethernet receive filter and ethertype classifier.
// Predicts results per accepted byte in a small scoreboard class and checks each result.
// Depends on emrx_pkg, emrx_if and the block's RTL.
module ethernet_rx_mac_filter_classifier_test;

    // Indexes beyond the last register; writes there must leave all settings alone
    localparam logic [emrx_pkg::CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [emrx_pkg::CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    localparam int PROTO_SLOTS     = emrx_pkg::PROTO_SLOTS_DEF;
    localparam int MAX_FRAME_BYTES = emrx_pkg::MAX_FRAME_BYTES_DEF;
    localparam int RESET_CYCLES    = 9;
    localparam int SETTLE_CYCLES   = 8;     // margin after the last result is checked
    localparam int QUIET_LIMIT     = 1000;  // cycles without any transaction before giving up
    localparam int PHASE_BYTES     = 90;

    typedef logic [7:0] octet_q[$];

    // ------------------------------------------------------------------
    // Scoreboard: own copy of the settings and of the per-frame state.
    // note_byte() works out what an accepted byte must produce,
    // check_result() pops the oldest expectation and compares.
    // ------------------------------------------------------------------
    class classifier_board;
        int unsigned                         mismatches;
        int unsigned                         checked;
        logic [emrx_pkg::MAC_W-1:0]          station_mac;
        logic [emrx_pkg::TYPE_W-1:0]         proto_type [emrx_pkg::SLOTS_MAX];
        logic [emrx_pkg::SLOTS_MAX-1:0]      proto_valid;
        int                                  byte_index;
        bit                                  own_match;
        bit                                  bcast_match;
        logic [7:0]                          type_high;
        bit                                  frame_accepted;
        logic [1:0]                          frame_verdict;
        logic [emrx_pkg::SLOT_W-1:0]         matched_slot;
        logic [emrx_pkg::TYPE_W-1:0]         frame_type;
        emrx_pkg::result_t                   due_results[$];

        function new();
            station_mac = '0;
            foreach (proto_type[i])
                proto_type[i] = '0;
            proto_valid = '0;
            mismatches  = 0;
            checked     = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            byte_index     = 0;
            own_match      = 1'b1;
            bcast_match    = 1'b1;
            type_high      = '0;
            frame_accepted = 1'b0;
            frame_verdict  = emrx_pkg::V_SHORT;
            matched_slot   = '0;
            frame_type     = '0;
        endfunction

        function void note_config(logic [emrx_pkg::CFG_IDX_W-1:0] idx,
                                  logic [emrx_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                emrx_pkg::CFG_STATION_MAC:  station_mac   = data[emrx_pkg::MAC_W-1:0];
                emrx_pkg::CFG_PROTO_TYPE_0: proto_type[0] = data[emrx_pkg::TYPE_W-1:0];
                emrx_pkg::CFG_PROTO_TYPE_1: proto_type[1] = data[emrx_pkg::TYPE_W-1:0];
                emrx_pkg::CFG_PROTO_TYPE_2: proto_type[2] = data[emrx_pkg::TYPE_W-1:0];
                emrx_pkg::CFG_PROTO_TYPE_3: proto_type[3] = data[emrx_pkg::TYPE_W-1:0];
                emrx_pkg::CFG_PROTO_VALID:  proto_valid   = data[emrx_pkg::SLOTS_MAX-1:0];
                default: ;
            endcase
        endfunction

        function void push_result(logic kind, logic [7:0] pb,
                                  logic [emrx_pkg::SLOT_W-1:0] slot, logic [1:0] verd,
                                  logic [emrx_pkg::TYPE_W-1:0] et, int plen, logic last);
            emrx_pkg::result_t r;
            r.result_kind  = kind;
            r.payload_byte = pb;
            r.proto_slot   = slot;
            r.verdict      = verd;
            r.ethertype    = et;
            r.payload_len  = plen[emrx_pkg::PLEN_W-1:0];
            r.run_last     = last;
            due_results.push_back(r);
        endfunction

        function void note_byte(logic [7:0] b, logic last_byte);
            int pos;
            int total;
            pos   = byte_index;
            total = pos + 1;
            if (total > MAX_FRAME_BYTES - 1)
                total = MAX_FRAME_BYTES - 1;

            if (pos < emrx_pkg::MAC_BYTES)
            begin
                if (b != station_mac[8*(emrx_pkg::MAC_BYTES-1-pos) +: 8])
                    own_match = 1'b0;
                if (b != emrx_pkg::BCAST_BYTE)
                    bcast_match = 1'b0;
            end
            else if (pos == emrx_pkg::TYPE_HI_POS)
            begin
                type_high = b;
            end
            else if (pos == emrx_pkg::TYPE_LO_POS)
            begin
                frame_type = {type_high, b};
                if (!own_match && !bcast_match)
                begin
                    frame_verdict = emrx_pkg::V_ADDR;
                end
                else
                begin
                    frame_verdict = emrx_pkg::V_NOHANDLER;
                    // lowest registered slot with this type wins
                    for (int i = PROTO_SLOTS - 1; i >= 0; i--)
                    begin
                        if (proto_valid[i] && proto_type[i] == frame_type)
                        begin
                            frame_verdict  = emrx_pkg::V_DELIVERED;
                            frame_accepted = 1'b1;
                            matched_slot   = i[emrx_pkg::SLOT_W-1:0];
                        end
                    end
                end
            end
            else if (pos >= emrx_pkg::HDR_LEN && frame_accepted)
            begin
                push_result(emrx_pkg::KIND_PAYLOAD, b, matched_slot, emrx_pkg::V_DELIVERED,
                            frame_type, total - emrx_pkg::HDR_LEN, !last_byte);
            end

            if (last_byte)
            begin
                if (total < emrx_pkg::HDR_LEN)
                    push_result(emrx_pkg::KIND_VERDICT, '0, '0, emrx_pkg::V_SHORT, '0, 0,
                                1'b1);
                else
                    push_result(emrx_pkg::KIND_VERDICT, '0,
                                frame_verdict == emrx_pkg::V_DELIVERED ? matched_slot : '0,
                                frame_verdict, frame_type, total - emrx_pkg::HDR_LEN, 1'b1);
                clear_frame();
            end
            else
            begin
                byte_index = total;
            end
        endfunction

        task report(string msg);
            $display("mismatch at result %0d: %s", checked, msg);
            mismatches++;
        endtask

        task compare_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report($sformatf("%s got %0h expected %0h", name, got, want));
        endtask

        task check_result(emrx_pkg::result_t got);
            emrx_pkg::result_t want;
            if (due_results.size() == 0)
            begin
                report($sformatf("result %h with nothing expected", got));
            end
            else
            begin
                want = due_results.pop_front();
                compare_field("result_kind",  16'(got.result_kind),  16'(want.result_kind));
                compare_field("payload_byte", 16'(got.payload_byte), 16'(want.payload_byte));
                compare_field("proto_slot",   16'(got.proto_slot),   16'(want.proto_slot));
                compare_field("verdict",      16'(got.verdict),      16'(want.verdict));
                compare_field("ethertype",    got.ethertype,         want.ethertype);
                compare_field("payload_len",  16'(got.payload_len),  16'(want.payload_len));
                compare_field("run_last",     16'(got.run_last),     16'(want.run_last));
            end
            checked++;
        endtask
    endclass

    logic clk;
    logic rst_n;
    bit   steady;       // when set, neither side idles
    int   bytes_sent;

    emrx_rx_if  rx ();
    emrx_res_if res ();
    emrx_cfg_if cfg ();

    classifier_board board = new();

    ethernet_rx_mac_filter_classifier #(
        .PROTO_SLOTS     (PROTO_SLOTS),
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .res   (res),
        .cfg   (cfg)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Result side back-pressure: ready is low with a chance of about 36 in 100 unless steady
    always @(posedge clk)
    begin
        res.ready <= steady || ($urandom_range(99) >= 36);
    end

    // Every transaction is sampled here, on the values seen before the edge.
    // A byte's results pass through the input register and the result FIFO before
    // they come out, so the order of the checks inside this block does not matter.
    always @(posedge clk)
    begin : monitor
        emrx_pkg::result_t seen;
        if (rst_n)
        begin
            if (res.valid && res.ready)
            begin
                seen.result_kind  = res.result_kind;
                seen.payload_byte = res.payload_byte;
                seen.proto_slot   = res.proto_slot;
                seen.verdict      = res.verdict;
                seen.ethertype    = res.ethertype;
                seen.payload_len  = res.payload_len;
                seen.run_last     = res.run_last;
                board.check_result(seen);
            end
            if (rx.valid && rx.ready)
                board.note_byte(rx.rx_byte, rx.frame_end);
            if (cfg.valid && cfg.ready)
                board.note_config(cfg.index, cfg.data);
        end
    end

    // Watchdog: a run of quiet cycles this long means the block is hung
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((rx.valid && rx.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Holds valid until the write is taken; the caller drops valid after the last one
    task automatic write_reg(logic [emrx_pkg::CFG_IDX_W-1:0] idx,
                             logic [emrx_pkg::CFG_DATA_W-1:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
    endtask

    // Loads all six registers; only called with no frame in flight
    task automatic load_settings(logic [emrx_pkg::MAC_W-1:0] mac,
                                 logic [emrx_pkg::TYPE_W-1:0] types [emrx_pkg::SLOTS_MAX],
                                 logic [emrx_pkg::SLOTS_MAX-1:0] valid_mask);
        write_reg(emrx_pkg::CFG_STATION_MAC,  mac);
        write_reg(emrx_pkg::CFG_PROTO_TYPE_0, emrx_pkg::CFG_DATA_W'(types[0]));
        write_reg(emrx_pkg::CFG_PROTO_TYPE_1, emrx_pkg::CFG_DATA_W'(types[1]));
        write_reg(emrx_pkg::CFG_PROTO_TYPE_2, emrx_pkg::CFG_DATA_W'(types[2]));
        write_reg(emrx_pkg::CFG_PROTO_TYPE_3, emrx_pkg::CFG_DATA_W'(types[3]));
        write_reg(emrx_pkg::CFG_PROTO_VALID,  emrx_pkg::CFG_DATA_W'(valid_mask));
        cfg.valid <= 1'b0;
        // writes are registered and land in the next cycle
        repeat (2) @(posedge clk);
    endtask

    // One byte; random idle cycles before it unless in the steady stretch.
    // valid stays high after acceptance so back-to-back bytes need no extra edge.
    task automatic send_byte(logic [7:0] b, logic last_byte);
        while (!steady && $urandom_range(99) < 36)
        begin
            rx.valid <= 1'b0;
            @(posedge clk);
        end
        rx.valid     <= 1'b1;
        rx.rx_byte   <= b;
        rx.frame_end <= last_byte;
        @(posedge clk);
        while (!rx.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_frame(octet_q f);
        foreach (f[i])
            send_byte(f[i], i == f.size() - 1);
    endtask

    // Drops valid, lets the monitor note the last byte, waits out every
    // expected result, then lets the pipe drain
    task automatic quiesce();
        rx.valid <= 1'b0;
        @(posedge clk);
        while (board.due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic octet_q build_frame(logic [emrx_pkg::MAC_W-1:0] dest,
                                           logic [emrx_pkg::TYPE_W-1:0] etype, int plen);
        octet_q f;
        for (int i = 0; i < emrx_pkg::MAC_BYTES; i++)
            f.push_back(dest[emrx_pkg::MAC_W-1-8*i -: 8]);
        for (int i = 0; i < emrx_pkg::MAC_BYTES; i++)
            f.push_back(8'($urandom_range(255)));
        f.push_back(etype[15:8]);
        f.push_back(etype[7:0]);
        for (int i = 0; i < plen; i++)
            f.push_back(8'($urandom_range(255)));
        return f;
    endfunction

    // Mostly well-formed frames aimed at the current settings, some noise
    task automatic random_frame();
        octet_q                     f;
        logic [emrx_pkg::MAC_W-1:0] dest;
        logic [15:0]                etype;
        int                         pick;
        int                         len;
        pick = $urandom_range(99);
        if (pick < 4)
        begin
            // pure noise of random length
            len = $urandom_range(1, 30);
            for (int i = 0; i < len; i++)
                f.push_back(8'($urandom_range(255)));
        end
        else
        begin
            pick = $urandom_range(99);
            if (pick < 45)
                dest = board.station_mac;
            else if (pick < 65)
                dest = '1;
            else if (pick < 80)
                dest = board.station_mac ^ (48'h1 << $urandom_range(emrx_pkg::MAC_W - 1));
            else if (pick < 90)
                dest = emrx_pkg::MAC_W'({$urandom, $urandom});
            else
                dest = {40'hFF_FFFF_FFFF, 8'($urandom_range(255))};

            if ($urandom_range(99) < 65)
                etype = board.proto_type[emrx_pkg::SLOT_W'($urandom_range(
                            emrx_pkg::SLOTS_MAX - 1))];
            else
                etype = 16'($urandom_range(16'hFFFF));

            pick = $urandom_range(99);
            if (pick < 10)
            begin
                // runt: header cut short somewhere in bytes 1..13
                f = build_frame(dest, etype, 0);
                len = $urandom_range(1, emrx_pkg::HDR_LEN - 1);
                f = f[0:len-1];
            end
            else if (pick < 18)
            begin
                f = build_frame(dest, etype, 0);
            end
            else
            begin
                f = build_frame(dest, etype, $urandom_range(1, 40));
            end
        end
        send_frame(f);
    endtask

    // Settings per phase: all slots valid first, then extremes, then duplicates, then random
    task automatic configure(int phase);
        logic [emrx_pkg::MAC_W-1:0]     mac;
        logic [emrx_pkg::TYPE_W-1:0]    types [emrx_pkg::SLOTS_MAX];
        logic [emrx_pkg::SLOTS_MAX-1:0] mask;
        logic [emrx_pkg::TYPE_W-1:0]    shared;
        mac    = emrx_pkg::MAC_W'({$urandom, $urandom});
        shared = emrx_pkg::TYPE_W'($urandom_range(16'hFFFF));
        foreach (types[i])
            types[i] = emrx_pkg::TYPE_W'($urandom_range(16'hFFFF));
        mask = emrx_pkg::SLOTS_MAX'($urandom_range(15));
        case (phase)
            0: mask = 4'hF;
            1:
            begin
                // own address equals broadcast, every type all ones, nothing registered
                mac = '1;
                foreach (types[i])
                    types[i] = 16'hFFFF;
                mask = 4'h0;
            end
            2:
            begin
                // all slots hold the same type: slot 1 must win over 2 and 3
                mac = '0;
                foreach (types[i])
                    types[i] = shared;
                mask = 4'hE;
            end
            3:
            begin
                // pairs of duplicates among random valid bits
                foreach (types[i])
                    types[i] = (i % 2) ? shared : ~shared;
            end
            default: ;
        endcase
        load_settings(mac, types, mask);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        logic [emrx_pkg::TYPE_W-1:0] types [emrx_pkg::SLOTS_MAX];
        octet_q                      f;
        int                          phase_end;

        rst_n        <= 1'b0;
        steady       <= 1'b0;
        bytes_sent   = 0;
        rx.valid     <= 1'b0;
        rx.rx_byte   <= '0;
        rx.frame_end <= 1'b0;
        cfg.valid    <= 1'b0;
        cfg.index    <= '0;
        cfg.data     <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed settings: common types, ethertype zero in slot 3.
        // Writes to the spare indexes must change nothing.
        types[0] = 16'h0800;
        types[1] = 16'h86DD;
        types[2] = 16'h0806;
        types[3] = 16'h0000;
        write_reg(CFG_SPARE_6, '1);
        write_reg(CFG_SPARE_7, emrx_pkg::CFG_DATA_W'({$urandom, $urandom}));
        load_settings(emrx_pkg::MAC_W'({$urandom, $urandom}), types, 4'hF);

        // Single-byte frame: too short at the very first byte
        send_byte(8'hFF, 1'b1);
        // Longest runt: 13 bytes, stops right after the ethertype high byte
        f = build_frame('1, 16'h0800, 0);
        f = f[0:emrx_pkg::HDR_LEN-2];
        send_frame(f);
        // Header only, broadcast, ethertype zero: delivered with no payload
        send_frame(build_frame('1, 16'h0000, 0));
        quiesce();

        // Random part, one settings phase after another; phase 3 runs without idling
        for (int phase = 0; phase < 6; phase++)
        begin
            configure(phase);
            steady    <= (phase == 3);
            phase_end = bytes_sent + PHASE_BYTES;
            while (bytes_sent < phase_end)
                random_frame();
            quiesce();
        end
        steady <= 1'b0;

        if (board.mismatches == 0 && board.due_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

>>> filelist.f
src/emrx_pkg.sv
src/emrx_if.sv
src/emrx_cfg_regs.sv
src/emrx_classifier.sv
src/emrx_result_fifo.sv
src/ethernet_rx_mac_filter_classifier.sv
src/emrx_checker.sv
sim/ethernet_rx_mac_filter_classifier_test.sv
